// ===== sv/scc_pkg.sv =====
package scc_pkg;

	localparam int WORD_BYTES = 8;
	localparam int WORD_W     = 8 * WORD_BYTES;
	localparam int WIDE_W     = 2 * WORD_W;
	localparam int LIMB_W     = 32;
	localparam int NUM_PAIRS  = 10;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic [7:0]        byte_t;

	localparam wide_t LCG_MUL = 128'h2360ED051FC65DA44385DF649FCCF645;

	localparam int KEY_STREAM    = 5;
	localparam int ANCHOR_STREAM = 6;
	localparam int MASK_STREAM   = 7;

	typedef enum logic [1:0] {
		OP_LOAD_FWD = 2'd0,
		OP_LOAD_INV = 2'd1,
		OP_START    = 2'd2,
		OP_PROCESS  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_DIRECTION   = 3'd0,
		CFG_KEY_LOW     = 3'd1,
		CFG_KEY_HIGH    = 3'd2,
		CFG_ANCHOR_LOW  = 3'd3,
		CFG_ANCHOR_HIGH = 3'd4,
		CFG_MASK_LOW    = 3'd5,
		CFG_MASK_HIGH   = 3'd6,
		CFG_UNUSED      = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		GEN_KEY    = 2'd0,
		GEN_ANCHOR = 2'd1,
		GEN_MASK   = 2'd2,
		GEN_SPARE  = 2'd3
	} gen_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_GO,
		ST_WAIT,
		ST_SUB,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       gen_load;
		logic       gen_from_ks;
		logic       go;
		gen_t       sel;
		logic       gen_capture;
		logic       ks_wr;
		logic       chain_draw;
		logic       mask_draw;
		logic       proc_prep;
		logic       rd_en;
		logic [2:0] rd_byte;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic step_done;
		logic out_busy;
	} status_t;

	// limb pairs (i, j) of the truncated 128x128 product, i + j <= 3
	function automatic logic [1:0] pair_a(input logic [3:0] k);
		logic [1:0] r;
		r = 2'd0;
		unique case (k)
			4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
			4'd4, 4'd5, 4'd6:       r = 2'd1;
			4'd7, 4'd8:             r = 2'd2;
			4'd9:                   r = 2'd3;
			default:                r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pair_m(input logic [3:0] k);
		logic [1:0] r;
		r = 2'd0;
		unique case (k)
			4'd0, 4'd4, 4'd7, 4'd9: r = 2'd0;
			4'd1, 4'd5, 4'd8:       r = 2'd1;
			4'd2, 4'd6:             r = 2'd2;
			4'd3:                   r = 2'd3;
			default:                r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic wide_t stream_inc(input gen_t g);
		wide_t r;
		r = '0;
		unique case (g)
			GEN_KEY:    r = wide_t'(2 * KEY_STREAM + 1);
			GEN_ANCHOR: r = wide_t'(2 * ANCHOR_STREAM + 1);
			GEN_MASK:   r = wide_t'(2 * MASK_STREAM + 1);
			default:    r = wide_t'(2 * KEY_STREAM + 1);
		endcase
		return r;
	endfunction

	// xsl-rr output of a generator state
	function automatic word_t gen_out(input wide_t s);
		word_t      x;
		logic [6:0] r;
		x = s[WIDE_W-1:WORD_W] ^ s[WORD_W-1:0];
		r = {1'b0, s[WIDE_W-1:WIDE_W-6]};
		return (x >> r) | (x << (7'd64 - r));
	endfunction

endpackage

// ===== sv/scc_item_if.sv =====
interface scc_item_if import scc_pkg::*; ();
	logic  valid;
	logic  ready;
	op_t   operation;
	byte_t table_index;
	byte_t table_value;
	word_t data_word;

	modport source (output valid, operation, table_index, table_value, data_word,
		input ready);
	modport sink (input valid, operation, table_index, table_value, data_word,
		output ready);
endinterface

// ===== sv/scc_result_if.sv =====
interface scc_result_if import scc_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t data_out;

	modport source (output valid, data_out, input ready);
	modport sink (input valid, data_out, output ready);
endinterface

// ===== sv/sbox_chained_stream_cipher.sv =====
// a table load is taken while idle; the block is ready again on the next cycle
// a process word takes one 128-bit generator step on the shared 32x32 multiplier,
// then eight table reads through one memory port
// a start runs five generator steps back to back
// arst_n clears control, keystream state, chain, mask and configuration to zero;
// the substitution tables hold nothing defined until loaded
module sbox_chained_stream_cipher import scc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	scc_item_if.sink        item,
	scc_result_if.source    result,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  word_t           cfg_data
);

	// transfer of one input item
	logic    accept;
	cmd_t    cmd;
	status_t status;
	logic    ready;

	assign accept     = item.valid && ready;
	assign item.ready = ready;

	// sequencer: seeding, generator steps, byte substitution, result hand-off
	scc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.operation(item.operation),
		.status   (status),
		.ready    (ready),
		.cmd      (cmd)
	);

	// generator, tables, chain and the output register, which lets a finished
	// word wait for its transfer while the next item is taken in
	scc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (item.operation),
		.table_index(item.table_index),
		.table_value(item.table_value),
		.data_word  (item.data_word),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_idx_t'(cfg_index)),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.out_ready  (result.ready),
		.status     (status),
		.out_valid  (result.valid),
		.data_out   (result.data_out)
	);

endmodule

// ===== sv/scc_lcg.sv =====
module scc_lcg import scc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  wide_t s_in,
	input  wide_t inc,
	output logic  done,
	output wide_t res
);

	wide_t             a_q;
	wide_t             acc_q;
	logic [3:0]        k_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W-1:0] prod_s1;
	logic [1:0]        sh_s1;
	logic              pv_s1;
	logic              last_s1;

	logic [1:0]        ia;
	logic [1:0]        jm;
	logic [LIMB_W-1:0] a_limb;
	logic [LIMB_W-1:0] m_limb;

	assign ia     = pair_a(k_q);
	assign jm     = pair_m(k_q);
	assign a_limb = a_q[{ia, 5'b00000} +: LIMB_W];
	assign m_limb = LCG_MUL[{jm, 5'b00000} +: LIMB_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= '0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pv_s1   <= busy_q;
			last_s1 <= busy_q && (k_q == 4'(NUM_PAIRS - 1));
			done_q  <= pv_s1 && last_s1;
			if (go) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 4'd1;
				if (k_q == 4'(NUM_PAIRS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= WORD_W'(a_limb) * WORD_W'(m_limb);
		sh_s1   <= 2'(ia + jm);
		if (go) begin
			a_q   <= s_in;
			acc_q <= inc;
		end else if (pv_s1) begin
			acc_q <= acc_q + (wide_t'(prod_s1) << {sh_s1, 5'b00000});
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

// ===== sv/scc_ctrl.sv =====
module scc_ctrl import scc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  op_t     operation,
	input  status_t status,
	output logic    ready,
	output cmd_t    cmd
);

	state_t     state_q, state_d;
	gen_t       gen_q, gen_d;
	logic       second_q, second_d;
	logic       proc_q, proc_d;
	logic [3:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			gen_q    <= GEN_KEY;
			second_q <= 1'b0;
			proc_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q  <= state_d;
			gen_q    <= gen_d;
			second_q <= second_d;
			proc_q   <= proc_d;
			cnt_q    <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		gen_d    = gen_q;
		second_d = second_q;
		proc_d   = proc_q;
		cnt_d    = cnt_q;
		ready    = 1'b0;
		cmd      = '0;
		cmd.sel  = gen_q;
		unique case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				if (accept && (operation == OP_START || operation == OP_PROCESS)) begin
					proc_d   = (operation == OP_PROCESS);
					gen_d    = GEN_KEY;
					second_d = 1'b0;
					state_d  = ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.gen_load    = 1'b1;
				cmd.gen_from_ks = proc_q;
				state_d         = ST_GO;
			end
			ST_GO: begin
				cmd.go  = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.step_done) begin
					cmd.gen_capture = 1'b1;
					if (proc_q) begin
						cmd.ks_wr     = 1'b1;
						cmd.proc_prep = 1'b1;
						cnt_d         = '0;
						state_d       = ST_SUB;
					end else begin
						unique case (gen_q)
							GEN_KEY: begin
								cmd.ks_wr = 1'b1;
								gen_d     = GEN_ANCHOR;
								second_d  = 1'b0;
								state_d   = ST_SEED;
							end
							GEN_ANCHOR: begin
								if (!second_q) begin
									second_d = 1'b1;
									state_d  = ST_GO;
								end else begin
									cmd.chain_draw = 1'b1;
									gen_d          = GEN_MASK;
									second_d       = 1'b0;
									state_d        = ST_SEED;
								end
							end
							GEN_MASK: begin
								if (!second_q) begin
									second_d = 1'b1;
									state_d  = ST_GO;
								end else begin
									cmd.mask_draw = 1'b1;
									state_d       = ST_IDLE;
								end
							end
							default: state_d = ST_IDLE;
						endcase
					end
				end
			end
			ST_SUB: begin
				if (cnt_q < 4'd8) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_byte = cnt_q[2:0];
					cnt_d       = cnt_q + 4'd1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== sv/scc_dp.sv =====
module scc_dp import scc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  op_t      operation,
	input  byte_t    table_index,
	input  byte_t    table_value,
	input  word_t    data_word,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  word_t    cfg_data,
	input  cmd_t     cmd,
	input  logic     out_ready,
	output status_t  status,
	output logic     out_valid,
	output word_t    data_out
);

	byte_t fwd_mem [256];
	byte_t inv_mem [256];

	logic  dir_q;
	wide_t kseed_q, aseed_q, mseed_q;
	wide_t ks_q;
	wide_t gen_q;
	word_t chain_q, mask_q;
	word_t word_q, w_q, key_q, x_q;
	word_t out_data_q;
	logic  out_valid_q;
	byte_t rd_fwd_s1, rd_inv_s1;
	logic  rd_v_s1;
	logic [2:0] rd_byte_s1;

	wide_t seed_sel;
	wide_t inc_sel;
	wide_t step_res;
	logic  step_done;
	word_t draw;
	byte_t rd_addr;

	assign inc_sel = stream_inc(cmd.sel);
	assign draw    = gen_out(step_res);
	assign rd_addr = w_q[{cmd.rd_byte, 3'b000} +: 8];

	always_comb begin
		unique case (cmd.sel)
			GEN_ANCHOR: seed_sel = aseed_q;
			GEN_MASK:   seed_sel = mseed_q;
			default:    seed_sel = kseed_q;
		endcase
	end

	scc_lcg u_lcg (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.go),
		.s_in  (gen_q),
		.inc   (inc_sel),
		.done  (step_done),
		.res   (step_res)
	);

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= 1'b0;
			kseed_q     <= '0;
			aseed_q     <= '0;
			mseed_q     <= '0;
			ks_q        <= '0;
			chain_q     <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
			rd_v_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DIRECTION:   dir_q                 <= cfg_data[0];
					CFG_KEY_LOW:     kseed_q[WORD_W-1:0]   <= cfg_data;
					CFG_KEY_HIGH:    kseed_q[WIDE_W-1:WORD_W] <= cfg_data;
					CFG_ANCHOR_LOW:  aseed_q[WORD_W-1:0]   <= cfg_data;
					CFG_ANCHOR_HIGH: aseed_q[WIDE_W-1:WORD_W] <= cfg_data;
					CFG_MASK_LOW:    mseed_q[WORD_W-1:0]   <= cfg_data;
					CFG_MASK_HIGH:   mseed_q[WIDE_W-1:WORD_W] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.ks_wr)
				ks_q <= step_res;
			if (cmd.chain_draw)
				chain_q <= draw;
			else if (cmd.finish)
				chain_q <= dir_q ? w_q : x_q;
			if (cmd.mask_draw)
				mask_q <= draw;
			rd_v_s1 <= cmd.rd_en;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			word_q <= data_word;
		if (cmd.gen_load)
			gen_q <= cmd.gen_from_ks ? ks_q : (inc_sel + seed_sel);
		else if (cmd.gen_capture)
			gen_q <= step_res;
		if (cmd.proc_prep) begin
			key_q <= draw;
			w_q   <= dir_q ? (word_q ^ draw) : (chain_q ^ word_q ^ mask_q);
		end
		rd_byte_s1 <= cmd.rd_byte;
		if (rd_v_s1)
			x_q[{rd_byte_s1, 3'b000} +: 8] <= dir_q ? rd_inv_s1 : rd_fwd_s1;
		if (cmd.finish)
			out_data_q <= dir_q ? (chain_q ^ x_q ^ mask_q) : (x_q ^ key_q);
	end

	// substitution tables
	always_ff @(posedge clk) begin
		if (accept && operation == OP_LOAD_FWD)
			fwd_mem[table_index] <= table_value;
		if (cmd.rd_en)
			rd_fwd_s1 <= fwd_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_LOAD_INV)
			inv_mem[table_index] <= table_value;
		if (cmd.rd_en)
			rd_inv_s1 <= inv_mem[rd_addr];
	end

	assign status.step_done = step_done;
	assign status.out_busy  = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign data_out         = out_data_q;

endmodule

// ===== sv/scc_chk.sv =====
module scc_chk import scc_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input op_t   operation,
	input logic  out_valid,
	input logic  out_ready,
	input word_t data_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(data_out))
		else $error("result changed while stalled");

	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_LOAD_FWD || operation == OP_LOAD_INV)
		|=> in_ready)
		else $error("table load did not complete in one cycle");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_START || operation == OP_PROCESS)
		|=> !in_ready)
		else $error("input taken while a word is in work");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_PROCESS |=> ##1 !$rose(out_valid))
		else $error("result too early");

endmodule

bind sbox_chained_stream_cipher scc_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (item.valid),
	.in_ready (item.ready),
	.operation(item.operation),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.data_out (result.data_out)
);
